@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, expr)
`endif
`endif

@@ sv/rbei_pkg.sv @@
// ----------------------------------------------------------------------------
// rbei_pkg
// Types, constants and helpers of the rigid body Euler integrator.
// ----------------------------------------------------------------------------
package rbei_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int MUL_W     = DATA_W + 1;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SAT_W     = PROD_W + 4;
  localparam int ADDR_W    = 5;
  localparam int REM_W     = 36;
  localparam int CNT_W     = 5;

  localparam logic [DATA_W-1:0] LIN_DAMP_RST = 32'd655;
  localparam logic [DATA_W-1:0] DT_RST       = 32'd1092;

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_LOAD_POS = 2'd1,
    MODE_LOAD_ORI = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_LIN_DAMP = 3'd0,
    REG_ANG_DAMP = 3'd1,
    REG_TIME_STEP = 3'd2,
    REG_LIN_LIM  = 3'd3,
    REG_ANG_LIM  = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FACT,
    ST_DAMP,
    ST_SQ,
    ST_POS,
    ST_ROT,
    ST_NQ,
    ST_SS,
    ST_SQRT,
    ST_DIV,
    ST_OUT0,
    ST_OUT1
  } state_e;

  typedef enum logic {
    RDU_SQRT = 1'b0,
    RDU_DIV  = 1'b1
  } rdu_op_e;

  typedef struct packed {
    logic    start;
    rdu_op_e op;
  } rdu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rdu_rsp_t;

  typedef struct packed {
    logic [1:0] qi;
    logic [1:0] wi;
    logic       neg;
    logic [1:0] comp;
    logic       fin;
  } rot_term_t;

  // Terms of the Hamilton product w*q, three per component, scalar part last.
  function automatic rot_term_t rot_term(input logic [3:0] k);
    rot_term_t t;
    t = '0;
    case (k)
      4'd0:  t = '{qi: 2'd3, wi: 2'd0, neg: 1'b0, comp: 2'd0, fin: 1'b0};
      4'd1:  t = '{qi: 2'd2, wi: 2'd1, neg: 1'b0, comp: 2'd0, fin: 1'b0};
      4'd2:  t = '{qi: 2'd1, wi: 2'd2, neg: 1'b1, comp: 2'd0, fin: 1'b1};
      4'd3:  t = '{qi: 2'd3, wi: 2'd1, neg: 1'b0, comp: 2'd1, fin: 1'b0};
      4'd4:  t = '{qi: 2'd0, wi: 2'd2, neg: 1'b0, comp: 2'd1, fin: 1'b0};
      4'd5:  t = '{qi: 2'd2, wi: 2'd0, neg: 1'b1, comp: 2'd1, fin: 1'b1};
      4'd6:  t = '{qi: 2'd3, wi: 2'd2, neg: 1'b0, comp: 2'd2, fin: 1'b0};
      4'd7:  t = '{qi: 2'd1, wi: 2'd0, neg: 1'b0, comp: 2'd2, fin: 1'b0};
      4'd8:  t = '{qi: 2'd0, wi: 2'd1, neg: 1'b1, comp: 2'd2, fin: 1'b1};
      4'd9:  t = '{qi: 2'd0, wi: 2'd0, neg: 1'b1, comp: 2'd3, fin: 1'b0};
      4'd10: t = '{qi: 2'd1, wi: 2'd1, neg: 1'b1, comp: 2'd3, fin: 1'b0};
      4'd11: t = '{qi: 2'd2, wi: 2'd2, neg: 1'b1, comp: 2'd3, fin: 1'b1};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic signed [SAT_W-1:0] sx_prod(input logic signed [PROD_W-1:0] x);
    return {{(SAT_W-PROD_W){x[PROD_W-1]}}, x};
  endfunction

  function automatic logic signed [SAT_W-1:0] sx_data(input logic signed [DATA_W-1:0] x);
    return {{(SAT_W-DATA_W){x[DATA_W-1]}}, x};
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = $signed({{(SAT_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
    lo = $signed({{(SAT_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}});
    if (x > hi) return $signed({1'b0, {(DATA_W-1){1'b1}}});
    if (x < lo) return $signed({1'b1, {(DATA_W-1){1'b0}}});
    return x[DATA_W-1:0];
  endfunction

endpackage

@@ sv/rbei_mul.sv @@
// ----------------------------------------------------------------------------
// rbei_mul
// Shared signed 33x33 multiplier with registered product.
// ----------------------------------------------------------------------------
module rbei_mul (
  input  logic                                     clk_i,
  input  logic                                     en_i,
  input  logic signed [rbei_pkg::MUL_W-1:0]        a_i,
  input  logic signed [rbei_pkg::MUL_W-1:0]        b_i,
  output logic signed [rbei_pkg::PROD_W-1:0]       prod_o
);

  logic signed [rbei_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ sv/rbei_rdu.sv @@
// ----------------------------------------------------------------------------
// rbei_rdu
// Iterative root/divide unit: one shared compare-subtract step per cycle.
// ----------------------------------------------------------------------------
module rbei_rdu #(
  parameter int FracBits = rbei_pkg::FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rbei_pkg::rdu_req_t                req_i,
  input  logic [2*rbei_pkg::DATA_W-1:0]     rad_i,
  input  logic [rbei_pkg::DATA_W-1:0]       mag_i,
  input  logic [rbei_pkg::DATA_W-1:0]       den_i,
  output rbei_pkg::rdu_rsp_t                rsp_o,
  output logic [rbei_pkg::DATA_W-1:0]       res_o
);

  localparam int DW = rbei_pkg::DATA_W;
  localparam int RW = rbei_pkg::REM_W;

  logic                              busy_q, done_q, first_q;
  rbei_pkg::rdu_op_e                 op_q;
  logic [rbei_pkg::CNT_W-1:0]        cnt_q;
  logic [RW-1:0]                     rem_q, rem_d;
  logic [DW-1:0]                     res_q, res_d;
  logic [2*DW-1:0]                   rad_q;
  logic [DW-1:0]                     den_q;
  logic [RW-1:0]                     cand, trial;
  logic                              ge;

  // sqrt brings down two radicand bits; divide shifts in a zero (not on the first step)
  always_comb begin
    if (op_q == rbei_pkg::RDU_DIV) begin
      cand  = first_q ? rem_q : {rem_q[RW-2:0], 1'b0};
      trial = {{(RW-DW){1'b0}}, den_q};
    end else begin
      cand  = {rem_q[RW-3:0], rad_q[2*DW-1 -: 2]};
      trial = {{(RW-DW-2){1'b0}}, res_q, 2'b01};
    end
    ge    = (cand >= trial);
    rem_d = ge ? (cand - trial) : cand;
    res_d = {res_q[DW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      first_q <= 1'b0;
      op_q   <= rbei_pkg::RDU_SQRT;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        first_q <= 1'b1;
        op_q    <= req_i.op;
        cnt_q   <= (req_i.op == rbei_pkg::RDU_DIV) ? rbei_pkg::CNT_W'(FracBits)
                                                   : rbei_pkg::CNT_W'(DW - 1);
      end else if (busy_q) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q - rbei_pkg::CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= (req_i.op == rbei_pkg::RDU_DIV) ? {{(RW-DW){1'b0}}, mag_i} : '0;
      res_q <= '0;
      rad_q <= rad_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      res_q <= res_d;
      rad_q <= {rad_q[2*DW-3:0], 2'b00};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign res_o      = res_q;

endmodule

@@ sv/rigid_body_euler_integrator.sv @@
// ----------------------------------------------------------------------------
// rigid_body_euler_integrator
// One rigid body pose step per tick transaction in signed fixed point.
// ----------------------------------------------------------------------------
// A tick transaction damps and rest-clamps both velocities, advances the
// position and the orientation quaternion and renormalizes it, then returns
// two results: position with linear velocity, then orientation with angular
// velocity (last set); a zero norm keeps the old orientation. Loads return
// nothing. Values are signed Q16.16 by default. A tick's length is set by a
// single shared multiplier that runs every product in turn, by a bit-per-cycle
// root/divide unit (32 root steps, FRAC_BITS+1 steps per quaternion
// component) and by the two result handshakes. in_ready_o is low from the
// accepted tick until its second result is taken.
`include "assert_macros.svh"

module rigid_body_euler_integrator #(
  parameter int FracBits = rbei_pkg::FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          mode_i,
  input  logic signed [rbei_pkg::DATA_W-1:0]  a_x_i,
  input  logic signed [rbei_pkg::DATA_W-1:0]  a_y_i,
  input  logic signed [rbei_pkg::DATA_W-1:0]  a_z_i,
  input  logic signed [rbei_pkg::DATA_W-1:0]  a_w_i,
  input  logic signed [rbei_pkg::DATA_W-1:0]  b_x_i,
  input  logic signed [rbei_pkg::DATA_W-1:0]  b_y_i,
  input  logic signed [rbei_pkg::DATA_W-1:0]  b_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                kind_o,
  output logic                                last_o,
  output logic signed [rbei_pkg::DATA_W-1:0]  out_x_o,
  output logic signed [rbei_pkg::DATA_W-1:0]  out_y_o,
  output logic signed [rbei_pkg::DATA_W-1:0]  out_z_o,
  output logic signed [rbei_pkg::DATA_W-1:0]  out_w_o,
  output logic signed [rbei_pkg::DATA_W-1:0]  vel_x_o,
  output logic signed [rbei_pkg::DATA_W-1:0]  vel_y_o,
  output logic signed [rbei_pkg::DATA_W-1:0]  vel_z_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rbei_pkg::ADDR_W-1:0]         paddr,
  input  logic [rbei_pkg::DATA_W-1:0]         pwdata,
  output logic [rbei_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int DW = rbei_pkg::DATA_W;
  localparam int MW = rbei_pkg::MUL_W;
  localparam int PW = rbei_pkg::PROD_W;
  localparam int SW = rbei_pkg::SAT_W;

  // configuration
  logic [DW-1:0] lin_damp_q, ang_damp_q, dt_q, lin_lim_q, ang_lim_q;
  rbei_pkg::reg_idx_e reg_idx;
  logic cfg_we;

  // state and working registers
  logic signed [DW-1:0] pos_q [3];
  logic signed [DW-1:0] ori_q [4];
  logic signed [DW-1:0] vel_q [6];
  logic signed [DW-1:0] nq_q  [4];
  logic signed [DW-1:0] rr_q  [4];
  logic signed [DW-1:0] f_q   [2];
  logic [2*DW-1:0]      sq_acc_q;
  logic [2*DW:0]        ss_acc_q;
  logic signed [SW-1:0] rot_acc_q;
  logic [DW-1:0]        n_q;

  rbei_pkg::state_e state_q, state_d;
  logic             ph_q, ph_d;
  logic [3:0]       idx_q, idx_d;

  // shared units
  logic                  mul_en;
  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]  prod;
  rbei_pkg::rdu_req_t    rdu_req;
  rbei_pkg::rdu_rsp_t    rdu_rsp;
  logic [DW-1:0]         rdu_res;
  logic [2*DW-1:0]       rad;
  logic [DW-1:0]         mag;

  logic                  in_acc;
  logic signed [PW-1:0]  sh_f, sh_f1;
  rbei_pkg::rot_term_t   term;
  logic [2:0]            vidx;
  logic [2:0]            widx;
  logic signed [DW-1:0]  nq_sel;
  logic signed [DW:0]    nq_neg;
  logic [2*DW-1:0]       sq_n;
  logic signed [SW-1:0]  rot_n, term_x;

  assign in_acc  = in_valid_i && in_ready_o;
  assign vidx    = idx_q[2:0];
  assign term    = rbei_pkg::rot_term(idx_q);
  assign widx    = 3'd3 + {1'b0, term.wi};
  assign sh_f    = prod >>> FracBits;
  assign sh_f1   = prod >>> (FracBits + 1);
  assign nq_sel  = nq_q[idx_q[1:0]];
  assign nq_neg  = -{nq_sel[DW-1], nq_sel};
  assign mag     = nq_sel[DW-1] ? nq_neg[DW-1:0] : nq_sel;
  assign rad     = ss_acc_q[2*DW] ? '1 : ss_acc_q[2*DW-1:0];
  assign sq_n    = sq_acc_q + prod[2*DW-1:0];
  assign term_x  = rbei_pkg::sx_prod(sh_f);
  assign rot_n   = term.neg ? (rot_acc_q - term_x) : (rot_acc_q + term_x);

  rbei_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  rbei_rdu #(.FracBits(FracBits)) u_rdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rdu_req),
    .rad_i  (rad),
    .mag_i  (mag),
    .den_i  (n_q),
    .rsp_o  (rdu_rsp),
    .res_o  (rdu_res)
  );

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = rbei_pkg::reg_idx_e'(paddr[rbei_pkg::ADDR_W-1:2]);

  always_comb begin
    unique case (reg_idx)
      rbei_pkg::REG_LIN_DAMP:  prdata = lin_damp_q;
      rbei_pkg::REG_ANG_DAMP:  prdata = ang_damp_q;
      rbei_pkg::REG_TIME_STEP: prdata = dt_q;
      rbei_pkg::REG_LIN_LIM:   prdata = lin_lim_q;
      rbei_pkg::REG_ANG_LIM:   prdata = ang_lim_q;
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_damp_q <= rbei_pkg::LIN_DAMP_RST;
      ang_damp_q <= '0;
      dt_q       <= rbei_pkg::DT_RST;
      lin_lim_q  <= '0;
      ang_lim_q  <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        rbei_pkg::REG_LIN_DAMP:  lin_damp_q <= pwdata;
        rbei_pkg::REG_ANG_DAMP:  ang_damp_q <= pwdata;
        rbei_pkg::REG_TIME_STEP: dt_q       <= pwdata;
        rbei_pkg::REG_LIN_LIM:   lin_lim_q  <= pwdata;
        rbei_pkg::REG_ANG_LIM:   ang_lim_q  <= pwdata;
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbei_pkg::ST_IDLE;
      ph_q    <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ph_d        = ~ph_q;
    idx_d       = idx_q;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    rdu_req     = '{start: 1'b0, op: rbei_pkg::RDU_SQRT};
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      rbei_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ph_d       = 1'b0;
        idx_d      = '0;
        if (in_valid_i && (mode_i == rbei_pkg::MODE_TICK)) begin
          state_d = rbei_pkg::ST_FACT;
        end
      end
      rbei_pkg::ST_FACT: begin
        mul_en = ~ph_q;
        mul_a  = {1'b0, idx_q[0] ? ang_damp_q : lin_damp_q};
        mul_b  = {1'b0, dt_q};
        if (ph_q) begin
          idx_d = idx_q + 4'd1;
          if (idx_q == 4'd1) begin
            state_d = rbei_pkg::ST_DAMP;
            idx_d   = '0;
          end
        end
      end
      rbei_pkg::ST_DAMP: begin
        mul_en = ~ph_q;
        mul_a  = {vel_q[vidx][DW-1], vel_q[vidx]};
        mul_b  = (vidx >= 3'd3) ? {f_q[1][DW-1], f_q[1]} : {f_q[0][DW-1], f_q[0]};
        if (ph_q) begin
          idx_d = idx_q + 4'd1;
          if (idx_q == 4'd5) begin
            state_d = rbei_pkg::ST_SQ;
            idx_d   = '0;
          end
        end
      end
      rbei_pkg::ST_SQ: begin
        mul_en = ~ph_q;
        mul_a  = {vel_q[vidx][DW-1], vel_q[vidx]};
        mul_b  = {vel_q[vidx][DW-1], vel_q[vidx]};
        if (ph_q) begin
          idx_d = idx_q + 4'd1;
          if (idx_q == 4'd5) begin
            state_d = rbei_pkg::ST_POS;
            idx_d   = '0;
          end
        end
      end
      rbei_pkg::ST_POS: begin
        mul_en = ~ph_q;
        mul_a  = {vel_q[vidx][DW-1], vel_q[vidx]};
        mul_b  = {1'b0, dt_q};
        if (ph_q) begin
          idx_d = idx_q + 4'd1;
          if (idx_q == 4'd2) begin
            state_d = rbei_pkg::ST_ROT;
            idx_d   = '0;
          end
        end
      end
      rbei_pkg::ST_ROT: begin
        mul_en = ~ph_q;
        mul_a  = {ori_q[term.qi][DW-1], ori_q[term.qi]};
        mul_b  = {vel_q[widx][DW-1], vel_q[widx]};
        if (ph_q) begin
          idx_d = idx_q + 4'd1;
          if (idx_q == 4'd11) begin
            state_d = rbei_pkg::ST_NQ;
            idx_d   = '0;
          end
        end
      end
      rbei_pkg::ST_NQ: begin
        mul_en = ~ph_q;
        mul_a  = {rr_q[idx_q[1:0]][DW-1], rr_q[idx_q[1:0]]};
        mul_b  = {1'b0, dt_q};
        if (ph_q) begin
          idx_d = idx_q + 4'd1;
          if (idx_q == 4'd3) begin
            state_d = rbei_pkg::ST_SS;
            idx_d   = '0;
          end
        end
      end
      rbei_pkg::ST_SS: begin
        mul_en = ~ph_q;
        mul_a  = {nq_sel[DW-1], nq_sel};
        mul_b  = {nq_sel[DW-1], nq_sel};
        if (ph_q) begin
          idx_d = idx_q + 4'd1;
          if (idx_q == 4'd3) begin
            state_d = rbei_pkg::ST_SQRT;
            idx_d   = '0;
          end
        end
      end
      rbei_pkg::ST_SQRT: begin
        rdu_req = '{start: ~ph_q, op: rbei_pkg::RDU_SQRT};
        if (ph_q) begin
          ph_d = 1'b1;
          if (rdu_rsp.done) begin
            ph_d    = 1'b0;
            // zero norm keeps the old orientation
            state_d = (rdu_res == '0) ? rbei_pkg::ST_OUT0 : rbei_pkg::ST_DIV;
          end
        end
      end
      rbei_pkg::ST_DIV: begin
        rdu_req = '{start: ~ph_q, op: rbei_pkg::RDU_DIV};
        if (ph_q) begin
          ph_d = 1'b1;
          if (rdu_rsp.done) begin
            ph_d  = 1'b0;
            idx_d = idx_q + 4'd1;
            if (idx_q == 4'd3) begin
              state_d = rbei_pkg::ST_OUT0;
              idx_d   = '0;
            end
          end
        end
      end
      rbei_pkg::ST_OUT0: begin
        out_valid_o = 1'b1;
        ph_d        = 1'b0;
        if (out_ready_i) state_d = rbei_pkg::ST_OUT1;
      end
      rbei_pkg::ST_OUT1: begin
        out_valid_o = 1'b1;
        ph_d        = 1'b0;
        if (out_ready_i) state_d = rbei_pkg::ST_IDLE;
      end
      default: begin
        state_d = rbei_pkg::ST_IDLE;
        ph_d    = 1'b0;
      end
    endcase
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) pos_q[i] <= '0;
      for (int i = 0; i < 3; i++) ori_q[i] <= '0;
      ori_q[3] <= DW'(1) << FracBits;
    end else if (in_acc && (mode_i == rbei_pkg::MODE_LOAD_POS)) begin
      pos_q[0] <= a_x_i;
      pos_q[1] <= a_y_i;
      pos_q[2] <= a_z_i;
    end else if (in_acc && (mode_i == rbei_pkg::MODE_LOAD_ORI)) begin
      ori_q[0] <= a_x_i;
      ori_q[1] <= a_y_i;
      ori_q[2] <= a_z_i;
      ori_q[3] <= a_w_i;
    end else if ((state_q == rbei_pkg::ST_POS) && ph_q) begin
      pos_q[idx_q[1:0]] <= rbei_pkg::sat32(rbei_pkg::sx_data(pos_q[idx_q[1:0]]) +
                                           rbei_pkg::sx_prod(sh_f));
    end else if ((state_q == rbei_pkg::ST_DIV) && ph_q && rdu_rsp.done) begin
      ori_q[idx_q[1:0]] <= nq_sel[DW-1] ? -$signed(rdu_res) : $signed(rdu_res);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (mode_i == rbei_pkg::MODE_TICK)) begin
      vel_q[0]  <= a_x_i;
      vel_q[1]  <= a_y_i;
      vel_q[2]  <= a_z_i;
      vel_q[3]  <= b_x_i;
      vel_q[4]  <= b_y_i;
      vel_q[5]  <= b_z_i;
      sq_acc_q  <= '0;
      ss_acc_q  <= '0;
      rot_acc_q <= '0;
    end
    if (ph_q) begin
      unique case (state_q)
        rbei_pkg::ST_FACT: begin
          f_q[idx_q[0]] <= rbei_pkg::sat32((SW'(1) << FracBits) - rbei_pkg::sx_prod(sh_f));
        end
        rbei_pkg::ST_DAMP: begin
          vel_q[vidx] <= rbei_pkg::sat32(rbei_pkg::sx_prod(sh_f));
        end
        rbei_pkg::ST_SQ: begin
          // rest test closes each vector
          if (idx_q == 4'd2) begin
            sq_acc_q <= '0;
            if ((sq_n >> FracBits) < {{DW{1'b0}}, lin_lim_q}) begin
              for (int i = 0; i < 3; i++) vel_q[i] <= '0;
            end
          end else begin
            sq_acc_q <= sq_n;
            if (idx_q == 4'd5) begin
              if ((sq_n >> FracBits) < {{DW{1'b0}}, ang_lim_q}) begin
                for (int i = 3; i < 6; i++) vel_q[i] <= '0;
              end
            end
          end
        end
        rbei_pkg::ST_ROT: begin
          if (term.fin) begin
            rr_q[term.comp] <= rbei_pkg::sat32(rot_n);
            rot_acc_q       <= '0;
          end else begin
            rot_acc_q <= rot_n;
          end
        end
        rbei_pkg::ST_NQ: begin
          nq_q[idx_q[1:0]] <= rbei_pkg::sat32(rbei_pkg::sx_data(ori_q[idx_q[1:0]]) +
                                              rbei_pkg::sx_prod(sh_f1));
        end
        rbei_pkg::ST_SS: begin
          ss_acc_q <= ss_acc_q + {1'b0, prod[2*DW-1:0]};
        end
        rbei_pkg::ST_SQRT: begin
          if (rdu_rsp.done) n_q <= rdu_res;
        end
        default: ;
      endcase
    end
  end

  // ---------------- results ----------------
  assign kind_o  = (state_q == rbei_pkg::ST_OUT1);
  assign last_o  = (state_q == rbei_pkg::ST_OUT1);
  assign out_x_o = kind_o ? ori_q[0] : pos_q[0];
  assign out_y_o = kind_o ? ori_q[1] : pos_q[1];
  assign out_z_o = kind_o ? ori_q[2] : pos_q[2];
  assign out_w_o = kind_o ? ori_q[3] : '0;
  assign vel_x_o = kind_o ? vel_q[3] : vel_q[0];
  assign vel_y_o = kind_o ? vel_q[4] : vel_q[1];
  assign vel_z_o = kind_o ? vel_q[5] : vel_q[2];

  // ---------------- assertions ----------------
  `ASSERT_NEVER(a_no_accept_while_result, clk_i, rst_ni, in_ready_o && out_valid_o)
  `ASSERT_NEVER(a_rdu_start_while_busy, clk_i, rst_ni, rdu_req.start && rdu_rsp.busy)
  `ASSERT_PROP(a_second_follows_first, clk_i, rst_ni, (out_valid_o && out_ready_i && !last_o) |=> (out_valid_o && last_o))

endmodule

@@ verif/rigid_body_euler_integrator_test.sv @@
// ----------------------------------------------------------------------------
// rigid_body_euler_integrator_test
// Self-checking bench for the rigid body pose integrator.
// ----------------------------------------------------------------------------
// Each tick transaction goes through a bit-exact pose model at acceptance.
// The model yields two expected results: position, then orientation. Returned
// results are compared field by field in order. A directed table covers
// reset state, saturation, zero norm and an ignored mode. Random phases follow,
// each with its own damping, time step and rest limits, extremes included.
// Both handshakes stall at random, with one phase free of stalls.
// ----------------------------------------------------------------------------
module rigid_body_euler_integrator_test;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
  localparam logic signed [31:0] MINV = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sd65536;
  localparam int FB = rbei_pkg::FRAC_BITS;
  localparam int AW = rbei_pkg::ADDR_W;
  localparam int DRAIN_CYCLES = 300;
  localparam int STALL_LIMIT = 20000;
  localparam int ITEMS_PER_PHASE = 90;

  typedef struct {
    logic kind;
    logic last;
    logic signed [31:0] x, y, z, w, vx, vy, vz;
  } pose_res_t;

  typedef struct {
    logic [1:0] mode;
    logic signed [31:0] ax, ay, az, aw, bx, by, bz;
    bit typed;
    logic signed [31:0] px, py, pz, qx, qy, qz, qw;
  } stim_row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [1:0] mode_i;
  logic signed [31:0] a_x_i, a_y_i, a_z_i, a_w_i, b_x_i, b_y_i, b_z_i;
  logic kind_o, last_o;
  logic signed [31:0] out_x_o, out_y_o, out_z_o, out_w_o, vel_x_o, vel_y_o, vel_z_o;
  logic psel, penable, pwrite, pready;
  logic [AW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  rigid_body_euler_integrator dut (.*);

  // model state and registers
  logic [31:0] lin_damp, ang_damp, dt, lin_lim, ang_lim;
  longint body_pos[3];
  longint body_quat[4];

  pose_res_t pending_res[$];
  stim_row_t dir_rows[$];
  bit quiet;
  int mismatches, stall_cycles, ticks_sent, loads_sent, results_checked;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp32(longint x);
    if (x > longint'(MAXV)) return longint'(MAXV);
    if (x < longint'(MINV)) return longint'(MINV);
    return x;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void damp_vec(inout longint v[3], input logic [31:0] damping,
                                   input logic [31:0] limit);
    longint unsigned prod, sq;
    longint f;
    prod = {32'd0, damping} * {32'd0, dt};
    f = clamp32(longint'(ONE) - longint'(prod >> FB));
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      v[i] = clamp32((v[i] * f) >>> FB);
      sq += longint'(v[i] * v[i]);
    end
    if ((sq >> FB) < {32'd0, limit})
      for (int i = 0; i < 3; i++) v[i] = 0;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return (a * b) >>> FB;
  endfunction

  function automatic void rotate_quat(longint w[3]);
    longint r[4], nq[4], mag, quo;
    longint unsigned s, t, n;
    longint q0, q1, q2, q3;
    q0 = body_quat[0]; q1 = body_quat[1]; q2 = body_quat[2]; q3 = body_quat[3];
    r[0] = clamp32(fmul(q3, w[0]) + fmul(w[1], q2) - fmul(w[2], q1));
    r[1] = clamp32(fmul(q3, w[1]) + fmul(w[2], q0) - fmul(w[0], q2));
    r[2] = clamp32(fmul(q3, w[2]) + fmul(w[0], q1) - fmul(w[1], q0));
    r[3] = clamp32(-(fmul(w[0], q0) + fmul(w[1], q1) + fmul(w[2], q2)));
    s = 0;
    for (int i = 0; i < 4; i++) begin
      nq[i] = clamp32(body_quat[i] +
                      ((r[i] * longint'({32'd0, dt})) >>> (FB + 1)));
      t = nq[i] * nq[i];
      s = (s > 64'hFFFF_FFFF_FFFF_FFFF - t) ? 64'hFFFF_FFFF_FFFF_FFFF : s + t;
    end
    n = int_sqrt(s);
    if (n == 0) return;  // zero norm keeps the old orientation
    for (int i = 0; i < 4; i++) begin
      mag = (nq[i] < 0) ? -nq[i] : nq[i];
      quo = longint'((longint'(mag) << FB) / n);
      body_quat[i] = clamp32((nq[i] < 0) ? -quo : quo);
    end
  endfunction

  function automatic void step_pose(stim_row_t r, output pose_res_t lin_res,
                                    output pose_res_t ang_res);
    longint v[3], w[3];
    v[0] = r.ax; v[1] = r.ay; v[2] = r.az;
    w[0] = r.bx; w[1] = r.by; w[2] = r.bz;
    damp_vec(v, lin_damp, lin_lim);
    damp_vec(w, ang_damp, ang_lim);
    for (int i = 0; i < 3; i++)
      body_pos[i] = clamp32(body_pos[i] + ((v[i] * longint'({32'd0, dt})) >>> FB));
    rotate_quat(w);
    lin_res = '{1'b0, 1'b0, 32'(body_pos[0]), 32'(body_pos[1]), 32'(body_pos[2]), 32'sd0,
                32'(v[0]), 32'(v[1]), 32'(v[2])};
    ang_res = '{1'b1, 1'b1, 32'(body_quat[0]), 32'(body_quat[1]), 32'(body_quat[2]),
                32'(body_quat[3]), 32'(w[0]), 32'(w[1]), 32'(w[2])};
  endfunction

  function automatic void add_row(logic [1:0] mode, logic signed [31:0] ax, ay, az, aw,
                                  bx, by, bz, bit typed = 0,
                                  logic signed [31:0] px = 0, py = 0, pz = 0,
                                  qx = 0, qy = 0, qz = 0, qw = 0);
    dir_rows.push_back('{mode, ax, ay, az, aw, bx, by, bz, typed, px, py, pz, qx, qy, qz, qw});
  endfunction

  function automatic logic signed [31:0] rand_field(int spread);
    case ($urandom_range(9))
      0: return MAXV;
      1: return MINV;
      2, 3: return $urandom();
      default: return $signed($urandom_range(0, 2 * spread)) - spread;
    endcase
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t r;
    int pick;
    r = '{default: 0};
    pick = $urandom_range(99);
    r.mode = (pick < 72) ? rbei_pkg::MODE_TICK : (pick < 84) ? rbei_pkg::MODE_LOAD_POS :
             (pick < 95) ? rbei_pkg::MODE_LOAD_ORI : MODE_UNUSED;
    r.ax = rand_field(1 << 20); r.ay = rand_field(1 << 20); r.az = rand_field(1 << 20);
    r.aw = rand_field(1 << 20);
    r.bx = rand_field(1 << 17); r.by = rand_field(1 << 17); r.bz = rand_field(1 << 17);
    if (r.mode == rbei_pkg::MODE_LOAD_ORI && $urandom_range(9) < 7) begin
      // mostly near-unit quaternions so later ticks stay meaningful
      r.ax = $signed($urandom_range(0, 80000)) - 40000;
      r.ay = $signed($urandom_range(0, 80000)) - 40000;
      r.az = $signed($urandom_range(0, 80000)) - 40000;
      r.aw = $signed($urandom_range(0, 40000)) + 40000;
    end
    return r;
  endfunction

  task automatic send_row(stim_row_t r);
    pose_res_t lin_res, ang_res;
    while (!quiet && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= r.mode;
    a_x_i <= r.ax; a_y_i <= r.ay; a_z_i <= r.az; a_w_i <= r.aw;
    b_x_i <= r.bx; b_y_i <= r.by; b_z_i <= r.bz;
    do @(posedge clk_i); while (!in_ready_o);
    case (r.mode)
      rbei_pkg::MODE_TICK: begin
        step_pose(r, lin_res, ang_res);
        if (r.typed) begin
          lin_res = '{1'b0, 1'b0, r.px, r.py, r.pz, 0, 0, 0, 0};
          ang_res = '{1'b1, 1'b1, r.qx, r.qy, r.qz, r.qw, 0, 0, 0};
        end
        pending_res.push_back(lin_res);
        pending_res.push_back(ang_res);
        ticks_sent++;
      end
      rbei_pkg::MODE_LOAD_POS: begin
        body_pos[0] = r.ax; body_pos[1] = r.ay; body_pos[2] = r.az;
        loads_sent++;
      end
      rbei_pkg::MODE_LOAD_ORI: begin
        body_quat[0] = r.ax; body_quat[1] = r.ay; body_quat[2] = r.az; body_quat[3] = r.aw;
        loads_sent++;
      end
      default: ;
    endcase
  endtask

  // hold off until no result is pending and the block has gone idle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(rbei_pkg::reg_idx_e idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AW'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      rbei_pkg::REG_LIN_DAMP: lin_damp = val;
      rbei_pkg::REG_ANG_DAMP: ang_damp = val;
      rbei_pkg::REG_TIME_STEP: dt = val;
      rbei_pkg::REG_LIN_LIM: lin_lim = val;
      rbei_pkg::REG_ANG_LIM: ang_lim = val;
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic signed [31:0] exp_v, logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // result side: check, stall at random, watchdog
  always @(posedge clk_i) begin
    pose_res_t e;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (psel && penable) || (out_valid_o && out_ready_i))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (out_valid_o && out_ready_i) begin
        if (pending_res.size() == 0) begin
          $error("result transaction with nothing expected");
          mismatches++;
        end else begin
          e = pending_res.pop_front();
          results_checked++;
          check_field("kind", e.kind, kind_o);
          check_field("last", e.last, last_o);
          check_field("out_x", e.x, out_x_o);
          check_field("out_y", e.y, out_y_o);
          check_field("out_z", e.z, out_z_o);
          check_field("out_w", e.w, out_w_o);
          check_field("vel_x", e.vx, vel_x_o);
          check_field("vel_y", e.vy, vel_y_o);
          check_field("vel_z", e.vz, vel_z_o);
        end
      end
      out_ready_i <= quiet || ($urandom_range(99) >= 29);
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] phase_cfg[5][5];
    rst_ni = 1'b0;
    in_valid_i = 1'b0; out_ready_i = 1'b0; mode_i = rbei_pkg::MODE_TICK;
    a_x_i = 0; a_y_i = 0; a_z_i = 0; a_w_i = 0; b_x_i = 0; b_y_i = 0; b_z_i = 0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    quiet = 0; mismatches = 0; stall_cycles = 0;
    ticks_sent = 0; loads_sent = 0; results_checked = 0;
    lin_damp = rbei_pkg::LIN_DAMP_RST; ang_damp = 0; dt = rbei_pkg::DT_RST;
    lin_lim = 0; ang_lim = 0;
    body_pos = '{0, 0, 0};
    body_quat = '{0, 0, 0, longint'(ONE)};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset state, saturation, zero norm, ignored mode
    add_row(rbei_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, ONE);
    add_row(rbei_pkg::MODE_LOAD_POS, MAXV, MAXV, MAXV, MAXV, 0, 0, 0);
    add_row(rbei_pkg::MODE_TICK, MAXV, MAXV, MAXV, MINV, MAXV, MAXV, MAXV);
    add_row(rbei_pkg::MODE_LOAD_POS, MINV, MINV, MINV, 0, MAXV, MAXV, MAXV);
    add_row(rbei_pkg::MODE_TICK, MINV, MINV, MINV, MAXV, MINV, MINV, MINV);
    add_row(rbei_pkg::MODE_LOAD_ORI, 0, 0, 0, 0, 0, 0, 0);
    add_row(rbei_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 1, MINV, MINV, MINV, 0, 0, 0, 0);
    add_row(rbei_pkg::MODE_LOAD_ORI, MAXV, MAXV, MAXV, MAXV, 0, 0, 0);
    add_row(rbei_pkg::MODE_TICK, 1, -1, 0, 0, MAXV, MINV, 1);
    add_row(rbei_pkg::MODE_LOAD_ORI, MINV, MINV, MINV, MINV, 0, 0, 0);
    add_row(rbei_pkg::MODE_TICK, -1, 1, MAXV, 0, MINV, MAXV, -1);
    add_row(MODE_UNUSED, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
    add_row(rbei_pkg::MODE_LOAD_POS, 0, 0, 0, 0, 0, 0, 0);
    add_row(rbei_pkg::MODE_LOAD_ORI, 0, 0, 0, ONE, 0, 0, 0);
    add_row(rbei_pkg::MODE_TICK, ONE, -ONE, 100, 0, 3000, -2000, 500);
    add_row(rbei_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0);
    foreach (dir_rows[i]) send_row(dir_rows[i]);

    // damping, angular damping, dt, linear limit, angular limit per phase
    phase_cfg[0] = '{0, 0, 0, 0, 0};
    phase_cfg[1] = '{655, 1200, 32'h10000, 0, 0};
    phase_cfg[2] = '{32'hFFFFFFFF, 32'hFFFFFFFF, 1092, 0, 0};
    phase_cfg[3] = '{$urandom_range(0, 5000), $urandom_range(0, 5000),
                     $urandom_range(100, 8000), $urandom_range(0, 1 << 22),
                     $urandom_range(0, 1 << 12)};
    phase_cfg[4] = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
    for (int p = 0; p < 5; p++) begin
      drain();
      reg_write(rbei_pkg::REG_LIN_DAMP, phase_cfg[p][0]);
      reg_write(rbei_pkg::REG_ANG_DAMP, phase_cfg[p][1]);
      reg_write(rbei_pkg::REG_TIME_STEP, phase_cfg[p][2]);
      reg_write(rbei_pkg::REG_LIN_LIM, phase_cfg[p][3]);
      reg_write(rbei_pkg::REG_ANG_LIM, phase_cfg[p][4]);
      quiet = (p == 1);  // one phase runs with no stalls on either side
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_row(rand_row());
      quiet = 0;
    end

    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d ticks and %0d loads over 6 register settings; %0d results checked.",
             ticks_sent, loads_sent, results_checked);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
